// ===== rtl/segmented_mobius_liouville_sieve_assert.svh =====
// Assertion macros used by the sieve datapath.
`ifndef SEGMENTED_MOBIUS_LIOUVILLE_SIEVE_ASSERT_SVH
`define SEGMENTED_MOBIUS_LIOUVILLE_SIEVE_ASSERT_SVH
// Checks that the consequent holds in the same cycle as the antecedent.
`define SMLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define SMLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/smls_pkg.sv =====
// Shared types and constants of the segmented Mobius and Liouville sieve.
package smls_pkg;

  // Base sieve ceiling and marks store depth.
  localparam logic [15:0] BASE_LIMIT = 16'hFFFF;
  localparam int MARK_DEPTH = 65536;

  // Configuration register indexes.
  localparam logic [3:0] CFG_SEG_COUNT = 4'd0;
  localparam logic [3:0] CFG_MODE      = 4'd1;

  // Datapath commands.
  typedef logic [4:0] op_t;
  localparam op_t OP_IDLE   = 5'd0;
  localparam op_t OP_SQRT   = 5'd1;
  localparam op_t OP_EXT    = 5'd2;
  localparam op_t OP_FILL   = 5'd3;
  localparam op_t OP_SV_I   = 5'd4;
  localparam op_t OP_SV_R   = 5'd5;
  localparam op_t OP_SV_J   = 5'd6;
  localparam op_t OP_COL_RD = 5'd7;
  localparam op_t OP_COL_WR = 5'd8;
  localparam op_t OP_INIT   = 5'd9;
  localparam op_t OP_PR_RD  = 5'd10;
  localparam op_t OP_PR_CHK = 5'd11;
  localparam op_t OP_DIV    = 5'd12;
  localparam op_t OP_OFF    = 5'd13;
  localparam op_t OP_WK_RD  = 5'd14;
  localparam op_t OP_WK_WR  = 5'd15;
  localparam op_t OP_PASS   = 5'd16;
  localparam op_t OP_PW_CHK = 5'd17;
  localparam op_t OP_EM_RD  = 5'd18;
  localparam op_t OP_EM_WR  = 5'd19;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic sqrt_done;
    logic ext_need;
    logic fill_done;
    logic sv_i_done;
    logic mark;
    logic j_done;
    logic col_done;
    logic init_done;
    logic pr_end;
    logic p_big;
    logic div_done;
    logic off_out;
    logic pass_zero;
    logic mode;
    logic pw_break;
    logic out_free;
    logic em_last;
  } sts_t;

endpackage

// ===== rtl/smls_if.sv =====
// Channel interfaces of the sieve: segment input, results and configuration.
interface smls_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] segment_start;
  modport source (output valid, output segment_start, input ready);
  modport sink (input valid, input segment_start, output ready);
endinterface

interface smls_out_if;
  logic              valid;
  logic              ready;
  logic [31:0]       value;
  logic signed [1:0] func_value;
  logic              last;
  modport source (output valid, output value, output func_value, output last, input ready);
  modport sink (input valid, input value, input func_value, input last, output ready);
endinterface

interface smls_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/smls_ctrl.sv =====
// Sequencer of the sieve: walks the phases of one segment and commands the datapath.
module smls_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  smls_pkg::sts_t sts,
  output smls_pkg::cmd_t cmd
);
  import smls_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SQRT   = 5'd1;
  localparam logic [4:0] S_EXT    = 5'd2;
  localparam logic [4:0] S_FILL   = 5'd3;
  localparam logic [4:0] S_SV_I   = 5'd4;
  localparam logic [4:0] S_SV_R   = 5'd5;
  localparam logic [4:0] S_SV_J   = 5'd6;
  localparam logic [4:0] S_COL_RD = 5'd7;
  localparam logic [4:0] S_COL_WR = 5'd8;
  localparam logic [4:0] S_INIT   = 5'd9;
  localparam logic [4:0] S_PR_RD  = 5'd10;
  localparam logic [4:0] S_PR_CHK = 5'd11;
  localparam logic [4:0] S_DIV    = 5'd12;
  localparam logic [4:0] S_OFF    = 5'd13;
  localparam logic [4:0] S_WK_RD  = 5'd14;
  localparam logic [4:0] S_WK_WR  = 5'd15;
  localparam logic [4:0] S_PASS   = 5'd16;
  localparam logic [4:0] S_PW_CHK = 5'd17;
  localparam logic [4:0] S_EM_RD  = 5'd18;
  localparam logic [4:0] S_EM_WR  = 5'd19;

  logic [4:0] state_r;
  logic [4:0] state_nxt;

  // Next state selection from the datapath status.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (sts.in_fire) state_nxt = S_SQRT;
      S_SQRT:   if (sts.sqrt_done) state_nxt = S_EXT;
      S_EXT:    state_nxt = sts.ext_need ? S_FILL : S_INIT;
      S_FILL:   if (sts.fill_done) state_nxt = S_SV_I;
      S_SV_I:   state_nxt = sts.sv_i_done ? S_COL_RD : S_SV_R;
      S_SV_R:   state_nxt = sts.mark ? S_SV_J : S_SV_I;
      S_SV_J:   if (sts.j_done) state_nxt = S_SV_I;
      S_COL_RD: state_nxt = S_COL_WR;
      S_COL_WR: state_nxt = sts.col_done ? S_INIT : S_COL_RD;
      S_INIT:   if (sts.init_done) state_nxt = S_PR_RD;
      S_PR_RD:  state_nxt = sts.pr_end ? S_EM_RD : S_PR_CHK;
      S_PR_CHK: state_nxt = sts.p_big ? S_EM_RD : S_DIV;
      S_DIV:    if (sts.div_done) state_nxt = S_OFF;
      S_OFF:    state_nxt = S_WK_RD;
      S_WK_RD:  state_nxt = sts.off_out ? S_PASS : S_WK_WR;
      S_WK_WR:  state_nxt = S_WK_RD;
      S_PASS: begin
        if (sts.pass_zero) state_nxt = S_DIV;
        else if (!sts.mode) state_nxt = S_PR_RD;
        else state_nxt = S_PW_CHK;
      end
      S_PW_CHK: state_nxt = sts.pw_break ? S_PR_RD : S_DIV;
      S_EM_RD:  state_nxt = S_EM_WR;
      S_EM_WR:  if (sts.out_free) state_nxt = sts.em_last ? S_IDLE : S_EM_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Command issued for each state.
  always_comb begin
    case (state_r)
      S_IDLE:   cmd.op = OP_IDLE;
      S_SQRT:   cmd.op = OP_SQRT;
      S_EXT:    cmd.op = OP_EXT;
      S_FILL:   cmd.op = OP_FILL;
      S_SV_I:   cmd.op = OP_SV_I;
      S_SV_R:   cmd.op = OP_SV_R;
      S_SV_J:   cmd.op = OP_SV_J;
      S_COL_RD: cmd.op = OP_COL_RD;
      S_COL_WR: cmd.op = OP_COL_WR;
      S_INIT:   cmd.op = OP_INIT;
      S_PR_RD:  cmd.op = OP_PR_RD;
      S_PR_CHK: cmd.op = OP_PR_CHK;
      S_DIV:    cmd.op = OP_DIV;
      S_OFF:    cmd.op = OP_OFF;
      S_WK_RD:  cmd.op = OP_WK_RD;
      S_WK_WR:  cmd.op = OP_WK_WR;
      S_PASS:   cmd.op = OP_PASS;
      S_PW_CHK: cmd.op = OP_PW_CHK;
      S_EM_RD:  cmd.op = OP_EM_RD;
      S_EM_WR:  cmd.op = OP_EM_WR;
      default:  cmd.op = OP_IDLE;
    endcase
  end

endmodule

// ===== rtl/smls_dp.sv =====
// Datapath of the sieve: configuration, square root, base sieve, stores and result register.
module smls_dp #(
  parameter int VALUE_BITS        = 32,
  parameter int SEGMENT_MAX       = 64,
  parameter int PRIME_TABLE_DEPTH = 8192
) (
  input  logic           clk,
  input  logic           rst_n,
  input  smls_pkg::cmd_t cmd,
  output smls_pkg::sts_t sts,
  smls_in_if.sink        in_chan,
  smls_out_if.source     out_chan,
  smls_cfg_if.sink       cfg_chan
);
  `include "segmented_mobius_liouville_sieve_assert.svh"
  import smls_pkg::*;

  localparam int VB  = VALUE_BITS;
  localparam int RW  = VB / 2 + 1;
  localparam int SQW = 2 * RW;
  localparam int BW  = (RW > 1) ? $clog2(RW) : 1;
  localparam int SIW = (SEGMENT_MAX > 1) ? $clog2(SEGMENT_MAX) : 1;
  localparam int TAW = $clog2(PRIME_TABLE_DEPTH);
  localparam int PCW = $clog2(PRIME_TABLE_DEPTH + 1);
  localparam int DW  = $clog2(VB);
  localparam int MW  = VB + 16;
  localparam int PBW = RW + 16;

  // Configuration registers.
  logic [6:0] seg_count_r;
  logic       mode_r;

  // Segment and control registers.
  logic [VB-1:0]  n_r, top_r, q_r, rem_r, dsh_r;
  logic [VB:0]    x_r, off_r;
  logic [6:0]     d_r;
  logic [RW-1:0]  root_r;
  logic [BW-1:0]  bit_r;
  logic [15:0]    limit_r, a_r, j_r, p_r;
  logic [8:0]     i_r;
  logic [PCW-1:0] count_r, idx_r;
  logic [DW-1:0]  dcnt_r;
  logic [MW-1:0]  mul_r;
  logic           zero_pass_r;

  // Stores and their registered read data.
  logic          marks_mem [MARK_DEPTH];
  logic [15:0]   table_mem [PRIME_TABLE_DEPTH];
  logic [1:0]    sign_mem  [SEGMENT_MAX];
  logic [VB-1:0] prod_mem  [SEGMENT_MAX];
  logic          mark_q_r;
  logic [15:0]   tab_q_r;
  logic [1:0]    sign_q_r;
  logic [VB-1:0] prod_q_r;

  // Result register.
  logic        ov_r, olast_r;
  logic [31:0] oval_r;
  logic [1:0]  ofv_r;

  // Input conditioning: count clamp, start clamp.
  logic [6:0]    d_in;
  logic [VB-1:0] n0, n1, n2;
  logic [VB:0]   maxstart;
  always_comb begin
    if (seg_count_r == 7'd0) d_in = 7'd1;
    else if (seg_count_r > 7'(SEGMENT_MAX)) d_in = 7'(SEGMENT_MAX);
    else d_in = seg_count_r;
    n0 = VB'(in_chan.segment_start);
    n1 = (n0 == '0) ? VB'(1) : n0;
    maxstart = ((VB+1)'(1) << VB) - (VB+1)'(d_in);
    n2 = ({1'b0, n1} > maxstart) ? VB'(maxstart) : n1;
  end

  // Sieve limit and square root step.
  logic [15:0]    t;
  logic           root_big;
  logic [RW-1:0]  cand;
  logic [SQW-1:0] cand_sq;
  logic [17:0]    i_sq;
  always_comb begin
    root_big = (RW > 16) ? (|(root_r >> 16)) : 1'b0;
    t = root_big ? BASE_LIMIT : 16'(root_r);
    cand = root_r | (RW'(1) << bit_r);
    cand_sq = SQW'(cand) * SQW'(cand);
    i_sq = 18'(i_r) * 18'(i_r);
  end

  // Restoring remainder step, one dividend bit per cycle.
  logic [VB:0]   rem_sh;
  logic          rem_ge;
  logic [VB-1:0] rem_new;
  always_comb begin
    rem_sh = {rem_r, dsh_r[VB-1]};
    rem_ge = rem_sh >= {1'b0, q_r};
    rem_new = rem_ge ? VB'(rem_sh - {1'b0, q_r}) : VB'(rem_sh);
  end

  // Segment entry update and result value.
  logic [MW-1:0] mulp;
  logic [1:0]    sign_upd;
  logic [VB-1:0] prod_upd, em_val;
  logic [1:0]    em_sign;
  always_comb begin
    mulp = MW'(prod_q_r) * MW'(p_r);
    sign_upd = zero_pass_r ? 2'b00 : 2'(-sign_q_r);
    if (zero_pass_r) prod_upd = prod_q_r;
    else if (mode_r || (sign_q_r != 2'b00)) prod_upd = VB'(mulp);
    else prod_upd = prod_q_r;
    em_val = n_r + VB'(a_r);
    em_sign = (prod_q_r != em_val) ? 2'(-sign_q_r) : sign_q_r;
  end

  // Status towards the sequencer.
  always_comb begin
    sts.in_fire   = in_chan.valid && in_chan.ready;
    sts.sqrt_done = bit_r == '0;
    sts.ext_need  = t > limit_r;
    sts.fill_done = a_r == t;
    sts.sv_i_done = i_sq > 18'(t);
    sts.mark      = mark_q_r;
    sts.j_done    = (17'(j_r) + 17'(i_r)) > 17'(t);
    sts.col_done  = a_r == t;
    sts.init_done = a_r == (16'(d_r) - 16'd1);
    sts.pr_end    = idx_r == count_r;
    sts.p_big     = PBW'(tab_q_r) > PBW'(root_r);
    sts.div_done  = dcnt_r == '0;
    sts.off_out   = off_r >= (VB+1)'(d_r);
    sts.pass_zero = zero_pass_r;
    sts.mode      = mode_r;
    sts.pw_break  = mul_r > MW'(top_r);
    sts.out_free  = !ov_r || out_chan.ready;
    sts.em_last   = a_r == (16'(d_r) - 16'd1);
  end

  // Neither channel takes a transfer while reset is held.
  assign in_chan.ready  = (cmd.op == OP_IDLE) && rst_n;
  assign cfg_chan.ready = rst_n;

  // Configuration transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r <= 7'd64;
      mode_r      <= 1'b1;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_SEG_COUNT: seg_count_r <= cfg_chan.data[6:0];
        CFG_MODE:      mode_r <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // Marks store: one write and one read port.
  logic        mark_we, mark_wd;
  logic [15:0] mark_wa, mark_ra;
  always_comb begin
    mark_we = (cmd.op == OP_FILL) || (cmd.op == OP_SV_J);
    mark_wa = (cmd.op == OP_FILL) ? a_r : j_r;
    mark_wd = (cmd.op == OP_FILL) ? (a_r >= 16'd2) : 1'b0;
    mark_ra = (cmd.op == OP_SV_I) ? 16'(i_r) : a_r;
  end
  always_ff @(posedge clk) begin
    if (mark_we) marks_mem[mark_wa] <= mark_wd;
    mark_q_r <= marks_mem[mark_ra];
  end

  // Prime table: appended during collection, read once per prime.
  logic tab_we;
  assign tab_we = (cmd.op == OP_COL_WR) && mark_q_r && (count_r < PCW'(PRIME_TABLE_DEPTH));
  always_ff @(posedge clk) begin
    if (tab_we) table_mem[count_r[TAW-1:0]] <= a_r;
    tab_q_r <= table_mem[idx_r[TAW-1:0]];
  end

  // Segment signs and products.
  logic           seg_we;
  logic [SIW-1:0] seg_wa, seg_ra;
  logic [1:0]     sign_wd;
  logic [VB-1:0]  prod_wd;
  always_comb begin
    seg_we  = (cmd.op == OP_INIT) || (cmd.op == OP_WK_WR);
    seg_wa  = (cmd.op == OP_INIT) ? a_r[SIW-1:0] : off_r[SIW-1:0];
    sign_wd = (cmd.op == OP_INIT) ? 2'b01 : sign_upd;
    prod_wd = (cmd.op == OP_INIT) ? VB'(1) : prod_upd;
    seg_ra  = ((cmd.op == OP_EM_RD) || (cmd.op == OP_EM_WR)) ? a_r[SIW-1:0] : off_r[SIW-1:0];
  end
  always_ff @(posedge clk) begin
    if (seg_we) begin
      sign_mem[seg_wa] <= sign_wd;
      prod_mem[seg_wa] <= prod_wd;
    end
    sign_q_r <= sign_mem[seg_ra];
    prod_q_r <= prod_mem[seg_ra];
  end

  // Table state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      limit_r <= 16'd1;
      ov_r    <= 1'b0;
    end else begin
      if (tab_we) count_r <= count_r + PCW'(1);
      if ((cmd.op == OP_COL_WR) && sts.col_done) limit_r <= t;
      if ((cmd.op == OP_EM_WR) && sts.out_free) ov_r <= 1'b1;
      else if (out_chan.ready) ov_r <= 1'b0;
    end
  end

  // Working registers, stepped by the command.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_IDLE: begin
        if (in_chan.valid) begin
          n_r    <= n2;
          d_r    <= d_in;
          top_r  <= n2 + VB'(d_in) - VB'(1);
          x_r    <= {1'b0, n2} + (VB+1)'(d_in);
          root_r <= '0;
          bit_r  <= BW'(RW - 1);
        end
      end
      OP_SQRT: begin
        if (cand_sq <= SQW'(x_r)) root_r <= cand;
        bit_r <= bit_r - BW'(1);
      end
      OP_EXT: a_r <= '0;
      OP_FILL: begin
        a_r <= a_r + 16'd1;
        if (sts.fill_done) i_r <= 9'd2;
      end
      OP_SV_I: if (sts.sv_i_done) a_r <= limit_r + 16'd1;
      OP_SV_R: begin
        if (mark_q_r) j_r <= 16'(i_sq);
        else i_r <= i_r + 9'd1;
      end
      OP_SV_J: begin
        j_r <= j_r + 16'(i_r);
        if (sts.j_done) i_r <= i_r + 9'd1;
      end
      OP_COL_WR: a_r <= sts.col_done ? 16'd0 : a_r + 16'd1;
      OP_INIT: begin
        a_r <= a_r + 16'd1;
        if (sts.init_done) idx_r <= '0;
      end
      OP_PR_RD: if (sts.pr_end) a_r <= '0;
      OP_PR_CHK: begin
        if (sts.p_big) a_r <= '0;
        else begin
          p_r         <= tab_q_r;
          q_r         <= mode_r ? VB'(tab_q_r) : VB'(32'(tab_q_r) * 32'(tab_q_r));
          zero_pass_r <= !mode_r;
          rem_r       <= '0;
          dsh_r       <= n_r;
          dcnt_r      <= DW'(VB - 1);
        end
      end
      OP_DIV: begin
        rem_r  <= rem_new;
        dsh_r  <= dsh_r << 1;
        dcnt_r <= dcnt_r - DW'(1);
      end
      OP_OFF: off_r <= (rem_r == '0) ? '0 : (VB+1)'(q_r - rem_r);
      OP_WK_WR: off_r <= off_r + {1'b0, q_r};
      OP_PASS: begin
        if (zero_pass_r) begin
          zero_pass_r <= 1'b0;
          q_r         <= VB'(p_r);
          rem_r       <= '0;
          dsh_r       <= n_r;
          dcnt_r      <= DW'(VB - 1);
        end else if (!mode_r) idx_r <= idx_r + PCW'(1);
        else mul_r <= MW'(q_r) * MW'(p_r);
      end
      OP_PW_CHK: begin
        if (sts.pw_break) idx_r <= idx_r + PCW'(1);
        else begin
          q_r    <= VB'(mul_r);
          rem_r  <= '0;
          dsh_r  <= n_r;
          dcnt_r <= DW'(VB - 1);
        end
      end
      OP_EM_WR: begin
        if (sts.out_free) begin
          oval_r  <= 32'(em_val);
          ofv_r   <= em_sign;
          olast_r <= sts.em_last;
          a_r     <= a_r + 16'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid      = ov_r;
  assign out_chan.value      = oval_r;
  assign out_chan.func_value = ofv_r;
  assign out_chan.last       = olast_r;

  // Walks stay inside the segment, the table covers the root, emission ends the segment.
  `SMLS_ASSERT_NOW(a_walk_in_seg, cmd.op == OP_WK_WR, off_r < (VB+1)'(d_r),
                   "walk left segment")
  `SMLS_ASSERT_NOW(a_table_covers, cmd.op == OP_PR_CHK, t <= limit_r,
                   "prime table short of root")
  `SMLS_ASSERT_NEXT(a_emit_hold, (cmd.op == OP_EM_WR) && ov_r && !out_chan.ready,
                    $stable(a_r), "emit index moved while stalled")
  `SMLS_ASSERT_NEXT(a_last_idle, (cmd.op == OP_EM_WR) && sts.out_free && sts.em_last,
                    cmd.op == OP_IDLE, "no return to idle after last result")

endmodule

// ===== rtl/segmented_mobius_liouville_sieve.sv =====
// Top level of the segmented Mobius and Liouville sieve.
// Use: a transfer on in_chan gives a segment start n; the block then returns
// segment_count results on out_chan, one per integer n, n+1, ..., each with
// the integer, its Mobius or Liouville value (as function_mode selects) and
// last set on the final one. cfg_chan is ready out of reset; index 0 writes
// segment_count, index 1 function_mode, and writes belong to idle periods.
// A segment_count of 0 acts as 1 and one above SEGMENT_MAX saturates; a start
// of 0 acts as 1 and one too near the top is lowered so the segment fits.
// Work per segment: an isqrt, then, when the root passes the primes already
// known, a base sieve over the marks store. Then every prime p up to the root
// is fetched and checked and takes one or more passes of the bit-serial
// remainder unit (Liouville mode adds power checks) plus a walk over its
// multiples inside the segment; the results follow. Only one segment is in
// work at a time; in_chan is ready again after the last result has entered
// the output register.
// Reset empties the prime table and restores segment_count 64 and Liouville
// mode; no clearing pass is needed. A stalled receiver holds the output
// register and pauses the result phase.
module segmented_mobius_liouville_sieve #(
  parameter int VALUE_BITS        = 32,
  parameter int SEGMENT_MAX       = 64,
  parameter int PRIME_TABLE_DEPTH = 8192
) (
  input logic        clk,
  input logic        rst_n,
  smls_in_if.sink    in_chan,
  smls_out_if.source out_chan,
  smls_cfg_if.sink   cfg_chan
);
  import smls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Phase sequencer.
  smls_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Arithmetic, stores and channel registers.
  smls_dp #(
    .VALUE_BITS        (VALUE_BITS),
    .SEGMENT_MAX       (SEGMENT_MAX),
    .PRIME_TABLE_DEPTH (PRIME_TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

endmodule

// ===== test/segmented_mobius_liouville_sieve_tb.sv =====
// Self-checking testbench of the segmented Mobius and Liouville sieve.
`timescale 1ns / 1ps

module segmented_mobius_liouville_sieve_tb;
  import smls_pkg::*;

  typedef struct {
    logic [31:0]       value;
    logic signed [1:0] func_value;
    logic              last;
  } sieve_result_t;

  localparam int WATCHDOG_LIMIT = 3000000;
  localparam int HOLD_CYCLES    = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  smls_in_if  in_chan();
  smls_out_if out_chan();
  smls_cfg_if cfg_chan();

  segmented_mobius_liouville_sieve DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #1 clk = ~clk;

  // Local copy of the registers, the base primes and the pending results.
  logic [6:0]    seg_count_reg = 7'd64;
  logic          mode_reg = 1'b1;
  int unsigned   base_primes[$];
  bit            composite[0:65535];
  logic [31:0]   pending_starts[$];
  sieve_result_t expected_results[$];
  int            error_count = 0;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  int            hold_request = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  int            idle_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic longint unsigned int_root(input longint unsigned x);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 26;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Work out the whole segment by trial division over the base primes.
  task automatic predict_segment(input logic [31:0] start);
    longint unsigned count, first, root, x, prod, rem, p;
    int sgn;
    sieve_result_t r;
    count = seg_count_reg;
    if (count == 0) count = 1;
    if (count > 64) count = 64;
    first = start;
    if (first == 0) first = 1;
    if (first > 64'h1_0000_0000 - count) first = 64'h1_0000_0000 - count;
    root = int_root(first + count);
    if (root > 65535) root = 65535;
    for (longint unsigned k = 0; k < count; k++) begin
      x = first + k;
      sgn = 1;
      prod = 1;
      foreach (base_primes[j]) begin
        p = base_primes[j];
        if (p > root || p > x) break;
        if (x % p == 0) begin
          if (mode_reg == 1'b0) begin
            if (x % (p * p) == 0) sgn = 0;
            sgn = -sgn;
            if (sgn != 0) prod = prod * p;
          end else begin
            rem = x;
            while (rem % p == 0) begin
              sgn = -sgn;
              prod = prod * p;
              rem = rem / p;
            end
          end
        end
      end
      if (prod != x) sgn = -sgn;
      r.value = x[31:0];
      r.func_value = 2'(sgn);
      r.last = (k == count - 1);
      expected_results = {expected_results, r};
    end
  endtask

  // Driver: offers the next pending segment start, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (pending_starts.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_chan.segment_start <= pending_starts.pop_front();
        in_chan.valid <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  always @(posedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen <= hold_request;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random stalls plus the hold-off.
  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else out_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin
    sieve_result_t exp_r;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) predict_segment(in_chan.segment_start);
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result for %0d", out_chan.value));
        end else begin
          exp_r = expected_results.pop_front();
          if (out_chan.value !== exp_r.value)
            report_mismatch($sformatf("value %0d, expected %0d",
                                      out_chan.value, exp_r.value));
          if (out_chan.func_value !== exp_r.func_value)
            report_mismatch($sformatf("function value %0d for %0d, expected %0d",
                                      out_chan.func_value, exp_r.value, exp_r.func_value));
          if (out_chan.last !== exp_r.last)
            report_mismatch($sformatf("last %b for %0d, expected %b",
                                      out_chan.last, exp_r.value, exp_r.last));
        end
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_register(input logic [3:0] index, input logic [7:0] data);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= index;
    cfg_chan.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    if (index == CFG_SEG_COUNT) seg_count_reg = data[6:0];
    else if (index == CFG_MODE) mode_reg = data[0];
  endtask

  task automatic wait_drained();
    while (!(pending_starts.size() == 0 && expected_results.size() == 0 && !in_chan.valid))
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Appends one segment start to the driver's queue.
  task automatic add_start(input logic [31:0] start);
    pending_starts = {pending_starts, start};
  endtask

  // Mostly small starts keep segments cheap; a few reach further.
  task automatic add_random(input int count);
    logic [31:0] start;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(19))
        0:       start = $urandom_range(4);
        1:       start = $urandom_range(1 << 24, 1);
        2, 3:    start = $urandom_range(1000000, 20000);
        default: start = $urandom_range(20000, 1);
      endcase
      add_start(start);
    end
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.segment_start = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_SEG_COUNT;
    cfg_chan.data = '0;
    for (int i = 2; i < 65536; i++) begin
      if (!composite[i]) begin
        base_primes = {base_primes, i};
        if (i < 256) begin
          for (int j = i * i; j < 65536; j += i) composite[j] = 1'b1;
        end
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: Liouville, full segments, small and edge starts.
    add_start(32'd0);
    add_start(32'd1);
    add_start(32'd2);
    add_start(32'd8);
    add_start(32'd36);
    add_start(32'd48);
    add_start(32'd1023);
    add_start(32'd65536);
    wait_drained();

    // Mobius with a zero count, which acts as one.
    write_register(CFG_SEG_COUNT, 8'd0);
    write_register(CFG_MODE, 8'd0);
    add_start(32'd1);
    add_start(32'd4);
    add_start(32'd30);
    add_start(32'd49);
    add_start(32'd210);
    add_start(32'd16769023);
    wait_drained();

    // Count above the maximum saturates; starts at the top of the range.
    write_register(CFG_SEG_COUNT, 8'd127);
    add_start(32'hFFFF_FFFF);
    add_start(32'd4294967231);
    add_start(32'd100);
    add_random(25);
    wait_drained();

    // Single integers, Liouville, sender mostly idle.
    write_register(CFG_SEG_COUNT, 8'd1);
    write_register(CFG_MODE, 8'd1);
    sender_idle_pct = 70;
    add_random(25);
    wait_drained();

    // Full Mobius segments, receiver mostly stalling, one long hold-off.
    write_register(CFG_SEG_COUNT, 8'd64);
    write_register(CFG_MODE, 8'd0);
    sender_idle_pct = 0;
    receiver_stall_pct = 70;
    add_random(25);
    hold_request++;
    wait_drained();

    // Odd count, Liouville, both sides idling at times.
    write_register(CFG_SEG_COUNT, 8'd37);
    write_register(CFG_MODE, 8'd1);
    sender_idle_pct = 22;
    receiver_stall_pct = 22;
    add_random(25);
    wait_drained();

    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
